### rtl/rart_pkg.sv
// Shared constants, types and helpers for the range add / range max tree.
package rart_pkg;

    localparam int LEAVES  = 1024;
    localparam int LEVELS  = $clog2(LEAVES);
    localparam int NODE_W  = LEVELS + 1;
    localparam int BND_W   = LEVELS + 2;
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int IDX_W   = 11;
    localparam int DATA_W  = 32;
    localparam logic [DATA_W-1:0] MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // Signed maximum of two raw words.
    function automatic logic [DATA_W-1:0] smax(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

### rtl/rart_if.sv
// Request and response channel interfaces of the range tree.
interface rart_req_if
    import rart_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [IDX_W-1:0]         range_start;
    logic [IDX_W-1:0]         range_end;
    logic signed [DATA_W-1:0] amount;

    modport source (output valid, func, range_start, range_end, amount, input ready);
    modport sink   (input valid, func, range_start, range_end, amount, output ready);
endinterface

interface rart_rsp_if
    import rart_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_maximum;

    modport source (output valid, range_maximum, input ready);
    modport sink   (input valid, range_maximum, output ready);
endinterface

### rtl/range_add_range_max_tree_unit.sv
// Lazy segment tree with range add and range maximum, built around two memories.
// One item at a time. Push pass: each level reads its pending add and, if one is set,
// pushes it into both children and clears it; 10 levels per boundary path. Range walk:
// takes the boundary nodes of each level. Rebuild (adds only): recomputes each parent
// along both boundary paths. A query may wait for the output register to be free.
// Reset: control clears at once, then a clearing pass zeroes both memories while no
// request beat is taken. A query result sits in an output register until taken.
module range_add_range_max_tree_unit
    import rart_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rart_req_if.sink    req,
    rart_rsp_if.source  rsp
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PS_RD,
        ST_PS_CHK,
        ST_PS_LEFT,
        ST_PS_RIGHT,
        ST_PS_ZERO,
        ST_RG_CHK,
        ST_RG_LW,
        ST_RG_RCHK,
        ST_RG_RW,
        ST_BD_RD,
        ST_BD_RIGHT,
        ST_BD_WR,
        ST_RESP
    } state_t;

    state_t              state_reg;
    func_t               func_reg;
    logic [DATA_W-1:0]   amt_reg;
    logic [IDX_W-1:0]    lo_reg;
    logic [IDX_W-1:0]    hi_reg;
    logic                pass_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [NODE_W-1:0]   node_reg;
    logic [BND_W-1:0]    l_reg;
    logic [BND_W-1:0]    r_reg;
    logic [DATA_W-1:0]   acc_reg;
    logic [DATA_W-1:0]   tag_reg;
    logic [DATA_W-1:0]   lmax_reg;
    logic [NODE_W-1:0]   clr_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;

    // Node maxima and pending adds.
    logic [DATA_W-1:0]   node_mem [2**NODE_W];
    logic [DATA_W-1:0]   pend_mem [LEAVES];
    logic [DATA_W-1:0]   nm_rdata_reg;
    logic [DATA_W-1:0]   pd_rdata_reg;

    logic                nm_we;
    logic [NODE_W-1:0]   nm_waddr;
    logic [DATA_W-1:0]   nm_wdata;
    logic [NODE_W-1:0]   nm_raddr;
    logic                pd_we;
    logic [LEVELS-1:0]   pd_waddr;
    logic [DATA_W-1:0]   pd_wdata;
    logic [LEVELS-1:0]   pd_raddr;

    logic [IDX_W-1:0]    in_lo;
    logic [IDX_W-1:0]    in_hi;
    logic [IDX_W-1:0]    path_x;
    logic [NODE_W-1:0]   path_leaf;
    logic [NODE_W-1:0]   push_node;
    logic [NODE_W-1:0]   ch_left;
    logic [NODE_W-1:0]   ch_right;
    logic [NODE_W-1:0]   bd_node;
    logic [BND_W-1:0]    r_dec;

    // Clamp the incoming range to the array.
    assign in_lo = (req.range_start > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : req.range_start;
    assign in_hi = (req.range_end > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : req.range_end;

    // Current boundary path and the nodes along it.
    assign path_x    = pass_reg ? (hi_reg - IDX_W'(1)) : lo_reg;
    assign path_leaf = NODE_W'(path_x) + NODE_W'(LEAVES);
    assign push_node = path_leaf >> lvl_reg;
    assign ch_left   = {node_reg[LEVELS-1:0], 1'b0};
    assign ch_right  = {node_reg[LEVELS-1:0], 1'b1};
    assign bd_node   = node_reg >> 1;
    assign r_dec     = r_reg - BND_W'(1);

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.range_maximum = out_data_reg;

    // Memory port control for each step of the sequencer.
    always_comb
    begin
        nm_we    = 1'b0;
        nm_waddr = node_reg;
        nm_wdata = '0;
        nm_raddr = node_reg;
        pd_we    = 1'b0;
        pd_waddr = node_reg[LEVELS-1:0];
        pd_wdata = '0;
        pd_raddr = node_reg[LEVELS-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                nm_we    = 1'b1;
                nm_waddr = clr_reg;
                pd_we    = ~clr_reg[LEVELS];
                pd_waddr = clr_reg[LEVELS-1:0];
            end
            ST_PS_RD:
            begin
                pd_raddr = push_node[LEVELS-1:0];
            end
            ST_PS_CHK:
            begin
                nm_raddr = ch_left;
                pd_raddr = ch_left[LEVELS-1:0];
            end
            ST_PS_LEFT:
            begin
                nm_we    = 1'b1;
                nm_waddr = ch_left;
                nm_wdata = nm_rdata_reg + tag_reg;
                pd_we    = ~ch_left[LEVELS];
                pd_waddr = ch_left[LEVELS-1:0];
                pd_wdata = pd_rdata_reg + tag_reg;
                nm_raddr = ch_right;
                pd_raddr = ch_right[LEVELS-1:0];
            end
            ST_PS_RIGHT:
            begin
                nm_we    = 1'b1;
                nm_waddr = ch_right;
                nm_wdata = nm_rdata_reg + tag_reg;
                pd_we    = ~ch_right[LEVELS];
                pd_waddr = ch_right[LEVELS-1:0];
                pd_wdata = pd_rdata_reg + tag_reg;
            end
            ST_PS_ZERO:
            begin
                pd_we    = 1'b1;
            end
            ST_RG_CHK:
            begin
                nm_raddr = l_reg[NODE_W-1:0];
                pd_raddr = l_reg[LEVELS-1:0];
            end
            ST_RG_LW:
            begin
                nm_we    = (func_reg == FUNC_ADD);
                nm_waddr = l_reg[NODE_W-1:0];
                nm_wdata = nm_rdata_reg + amt_reg;
                pd_we    = (func_reg == FUNC_ADD) && !l_reg[LEVELS];
                pd_waddr = l_reg[LEVELS-1:0];
                pd_wdata = pd_rdata_reg + amt_reg;
            end
            ST_RG_RCHK:
            begin
                nm_raddr = r_dec[NODE_W-1:0];
                pd_raddr = r_dec[LEVELS-1:0];
            end
            ST_RG_RW:
            begin
                nm_we    = (func_reg == FUNC_ADD);
                nm_waddr = r_reg[NODE_W-1:0];
                nm_wdata = nm_rdata_reg + amt_reg;
                pd_we    = (func_reg == FUNC_ADD) && !r_reg[LEVELS];
                pd_waddr = r_reg[LEVELS-1:0];
                pd_wdata = pd_rdata_reg + amt_reg;
            end
            ST_BD_RD:
            begin
                nm_raddr = {bd_node[LEVELS-1:0], 1'b0};
                pd_raddr = bd_node[LEVELS-1:0];
            end
            ST_BD_RIGHT:
            begin
                nm_raddr = ch_right;
            end
            ST_BD_WR:
            begin
                nm_we    = 1'b1;
                nm_wdata = smax(lmax_reg, nm_rdata_reg) + tag_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Tree memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            node_mem[nm_waddr] <= nm_wdata;
        end
        nm_rdata_reg <= node_mem[nm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pd_we)
        begin
            pend_mem[pd_waddr] <= pd_wdata;
        end
        pd_rdata_reg <= pend_mem[pd_raddr];
    end

    // Sequencer: push, range walk, rebuild, response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            func_reg      <= FUNC_ADD;
        end
        else
        begin
            // The response step reloads the output register itself when a beat leaves.
            if (rsp.valid && rsp.ready && state_reg != ST_RESP)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + NODE_W'(1);
                    if (&clr_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        func_reg <= func_t'(req.func);
                        amt_reg  <= req.amount;
                        lo_reg   <= in_lo;
                        hi_reg   <= in_hi;
                        acc_reg  <= MAX_NEG;
                        pass_reg <= 1'b0;
                        lvl_reg  <= LVL_W'(LEVELS);
                        if (in_lo >= in_hi)
                        begin
                            state_reg <= (func_t'(req.func) == FUNC_QUERY) ? ST_RESP : ST_IDLE;
                        end
                        else if (func_t'(req.func) == FUNC_ADD && req.amount == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_PS_RD;
                        end
                    end
                end
                ST_PS_RD:
                begin
                    node_reg  <= push_node;
                    state_reg <= ST_PS_CHK;
                end
                ST_PS_CHK:
                begin
                    tag_reg <= pd_rdata_reg;
                    if (pd_rdata_reg != '0)
                    begin
                        state_reg <= ST_PS_LEFT;
                    end
                    else if (lvl_reg != LVL_W'(1))
                    begin
                        lvl_reg   <= lvl_reg - LVL_W'(1);
                        state_reg <= ST_PS_RD;
                    end
                    else if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        lvl_reg   <= LVL_W'(LEVELS);
                        state_reg <= ST_PS_RD;
                    end
                    else
                    begin
                        l_reg     <= BND_W'(lo_reg) + BND_W'(LEAVES);
                        r_reg     <= BND_W'(hi_reg) + BND_W'(LEAVES);
                        state_reg <= ST_RG_CHK;
                    end
                end
                ST_PS_LEFT:
                begin
                    state_reg <= ST_PS_RIGHT;
                end
                ST_PS_RIGHT:
                begin
                    state_reg <= ST_PS_ZERO;
                end
                ST_PS_ZERO:
                begin
                    if (lvl_reg != LVL_W'(1))
                    begin
                        lvl_reg   <= lvl_reg - LVL_W'(1);
                        state_reg <= ST_PS_RD;
                    end
                    else if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        lvl_reg   <= LVL_W'(LEVELS);
                        state_reg <= ST_PS_RD;
                    end
                    else
                    begin
                        l_reg     <= BND_W'(lo_reg) + BND_W'(LEAVES);
                        r_reg     <= BND_W'(hi_reg) + BND_W'(LEAVES);
                        state_reg <= ST_RG_CHK;
                    end
                end
                ST_RG_CHK:
                begin
                    if (l_reg < r_reg)
                    begin
                        state_reg <= l_reg[0] ? ST_RG_LW : ST_RG_RCHK;
                    end
                    else if (func_reg == FUNC_ADD)
                    begin
                        pass_reg  <= 1'b0;
                        node_reg  <= NODE_W'(lo_reg) + NODE_W'(LEAVES);
                        state_reg <= ST_BD_RD;
                    end
                    else
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RG_LW:
                begin
                    acc_reg   <= smax(acc_reg, nm_rdata_reg);
                    l_reg     <= l_reg + BND_W'(1);
                    state_reg <= ST_RG_RCHK;
                end
                ST_RG_RCHK:
                begin
                    if (r_reg[0])
                    begin
                        r_reg     <= r_dec;
                        state_reg <= ST_RG_RW;
                    end
                    else
                    begin
                        l_reg     <= l_reg >> 1;
                        r_reg     <= r_reg >> 1;
                        state_reg <= ST_RG_CHK;
                    end
                end
                ST_RG_RW:
                begin
                    acc_reg   <= smax(acc_reg, nm_rdata_reg);
                    l_reg     <= l_reg >> 1;
                    r_reg     <= r_reg >> 1;
                    state_reg <= ST_RG_CHK;
                end
                ST_BD_RD:
                begin
                    if (node_reg > NODE_W'(1))
                    begin
                        node_reg  <= bd_node;
                        state_reg <= ST_BD_RIGHT;
                    end
                    else if (!pass_reg)
                    begin
                        pass_reg  <= 1'b1;
                        node_reg  <= NODE_W'(hi_reg - IDX_W'(1)) + NODE_W'(LEAVES);
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_BD_RIGHT:
                begin
                    lmax_reg  <= nm_rdata_reg;
                    tag_reg   <= pd_rdata_reg;
                    state_reg <= ST_BD_WR;
                end
                ST_BD_WR:
                begin
                    state_reg <= ST_BD_RD;
                end
                ST_RESP:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= acc_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // No request beat is taken during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    // A result appears only from the response step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result without a query");

    // Push level stays within the tree height.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PS_RD || state_reg == ST_PS_ZERO)
            |-> (lvl_reg >= LVL_W'(1) && lvl_reg <= LVL_W'(LEVELS)))
        else $error("push level out of range");

    // The left side of the range walk never addresses beyond the node store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RG_LW) |-> !l_reg[BND_W-1])
        else $error("range walk left node out of range");

    // The right side of the range walk never addresses beyond the node store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RG_RW) |-> !r_reg[BND_W-1])
        else $error("range walk right node out of range");

endmodule
